// File: design/days_between_dates_defines.svh
// Assertion macros for the days-between-dates top level.
`ifndef DAYS_BETWEEN_DATES_DEFINES_SVH
`define DAYS_BETWEEN_DATES_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DBD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds after ante.
`define DBD_ASSERT_LAT3(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##3 (cons)) \
      else $error(msg);

`endif

// File: design/dbd_pkg.sv
// Types, constants and calendar tables for the days-between-dates block.
package dbd_pkg;

   localparam int unsigned DayWidth   = 5;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned YearWidth  = 14;
   localparam int unsigned DoyWidth   = 9;
   localparam int unsigned CentWidth  = 8;
   localparam int unsigned DnumWidth  = 23;

   localparam logic [MonthWidth-1:0] MonthJan = 4'd1;
   localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;
   localparam logic [MonthWidth-1:0] MonthDec = 4'd12;

   // Reciprocal of 100 scaled by 2**19; exact floor for values below 16384.
   localparam logic [12:0] Recip100   = 13'd5243;
   localparam int unsigned Recip100Sh = 19;

   // Stage one result for one date.
   typedef struct packed {
      logic                  fields_ok;  // month, year and nonzero day in range
      logic                  len_ok;     // day within the non-leap month length
      logic                  feb29;      // February 29
      logic [YearWidth-1:0]  year;
      logic [CentWidth-1:0]  year_cent;  // year / 100
      logic [YearWidth-1:0]  adj_year;   // year counted from March
      logic [CentWidth-1:0]  adj_cent;   // adj_year / 100
      logic [DoyWidth-1:0]   doy;        // day of year from March 1
   } front_type;

   // Stage two result for one date.
   typedef struct packed {
      logic                  valid;
      logic [DnumWidth-1:0]  dnum;
   } back_type;

   // Non-leap length of a month.
   function automatic logic [DayWidth-1:0] month_len(input logic [MonthWidth-1:0] m);
      logic [DayWidth-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   // Days from March 1 to the first of the month.
   function automatic logic [DoyWidth-1:0] month_offset(input logic [MonthWidth-1:0] m);
      logic [DoyWidth-1:0] off;
      case (m)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

// File: design/dbd_front.sv
// First pipeline stage for one date: range checks, day of year, century quotients.
module dbd_front #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                      clock,
   input  logic [4:0]                day,
   input  logic [3:0]                month,
   input  logic [13:0]               year,
   output dbd_pkg::front_type        front_ff
);
   import dbd_pkg::*;

   localparam logic [16:0] YearLimit = 17'(MAX_YEAR);

   front_type            front_in;
   logic [YearWidth-1:0] adj_year;

   // Shift January and February into the previous year
   assign adj_year = (month <= MonthFeb) ? (year - 14'd1) : year;

   // Check ranges and look up month offset
   always_comb begin
      front_in.fields_ok = (month >= MonthJan) && (month <= MonthDec) &&
                           (year != '0) && ({3'b000, year} <= YearLimit) &&
                           (day != '0);
      front_in.len_ok    = (day <= month_len(month));
      front_in.feb29     = (month == MonthFeb) && (day == 5'd29);
      front_in.year      = year;
      front_in.year_cent = CentWidth'((28'(year) * 28'(Recip100)) >> Recip100Sh);
      front_in.adj_year  = adj_year;
      front_in.adj_cent  = CentWidth'((28'(adj_year) * 28'(Recip100)) >> Recip100Sh);
      front_in.doy       = DoyWidth'(month_offset(month) + {4'b0000, day} - 9'd1);
   end

   // Hold the stage result
   always_ff @(posedge clock) begin
      front_ff <= front_in;
   end

endmodule

// File: design/dbd_back.sv
// Second pipeline stage for one date: leap-year check and day number.
module dbd_back (
   input  logic                      clock,
   input  dbd_pkg::front_type        front,
   output dbd_pkg::back_type         back_ff
);
   import dbd_pkg::*;

   back_type              back_in;
   logic                  cent_year;
   logic                  leap;
   logic [DnumWidth-1:0]  year_days;

   // Decide leap year from the century quotient
   assign cent_year = (15'(front.year_cent) * 15'd100) == {1'b0, front.year};
   assign leap      = cent_year ? (front.year_cent[1:0] == 2'b00) :
                                  (front.year[1:0] == 2'b00);
   assign year_days = DnumWidth'(front.adj_year) * 23'd365;

   // Combine validity and build the day number
   always_comb begin
      back_in.valid = front.fields_ok && (front.len_ok || (front.feb29 && leap));
      back_in.dnum  = year_days
                      + DnumWidth'(front.adj_year >> 2)
                      - DnumWidth'(front.adj_cent)
                      + DnumWidth'(front.adj_cent >> 2)
                      + DnumWidth'(front.doy);
   end

   // Hold the stage result
   always_ff @(posedge clock) begin
      back_ff <= back_in;
   end

endmodule

// File: design/days_between_dates.sv
// Top level of the days-between-dates block: item handshake, valid pipeline, subtraction.
// Result: strobes once its item has passed the front, back and result registers.
// Throughput: one item per cycle; start is taken whenever busy is low.
// Stages: range checks and divide-by-100, then leap check and day number, then subtract.
// Reset: synchronous, active high; clears the valid pipeline and holds busy high.
// The receiver cannot stall, so busy is low whenever reset is low.
module days_between_dates #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [4:0]          req_first_day,
   input  logic [3:0]          req_first_month,
   input  logic [13:0]         req_first_year,
   input  logic [4:0]          req_second_day,
   input  logic [3:0]          req_second_month,
   input  logic [13:0]         req_second_year,
   output logic                rsp_strobe,
   output logic                rsp_dates_valid,
   output logic signed [22:0]  rsp_day_difference
);
   import dbd_pkg::*;

`include "days_between_dates_defines.svh"

   logic                        accept;
   logic                        s1_valid_ff;
   logic                        s2_valid_ff;
   logic                        rsp_strobe_ff;
   logic                        rsp_dates_valid_ff;
   logic                        rsp_dates_valid_in;
   logic signed [DnumWidth-1:0] rsp_day_difference_ff;
   logic signed [DnumWidth-1:0] rsp_day_difference_in;
   front_type                   first_front;
   front_type                   second_front;
   back_type                    first_back;
   back_type                    second_back;

   // Take an item in any cycle outside reset
   assign busy   = reset;
   assign accept = start && !busy;

   dbd_front #(.MAX_YEAR(MAX_YEAR)) u_first_front (
      .clock    (clock),
      .day      (req_first_day),
      .month    (req_first_month),
      .year     (req_first_year),
      .front_ff (first_front)
   );

   dbd_front #(.MAX_YEAR(MAX_YEAR)) u_second_front (
      .clock    (clock),
      .day      (req_second_day),
      .month    (req_second_month),
      .year     (req_second_year),
      .front_ff (second_front)
   );

   dbd_back u_first_back (
      .clock   (clock),
      .front   (first_front),
      .back_ff (first_back)
   );

   dbd_back u_second_back (
      .clock   (clock),
      .front   (second_front),
      .back_ff (second_back)
   );

   // Subtract day numbers and zero the result on an invalid date
   always_comb begin
      rsp_dates_valid_in    = first_back.valid && second_back.valid;
      rsp_day_difference_in = rsp_dates_valid_in ?
                              signed'(second_back.dnum - first_back.dnum) : '0;
   end

   // Advance the valid bits with the item
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         s2_valid_ff   <= s1_valid_ff;
         rsp_strobe_ff <= s2_valid_ff;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      rsp_dates_valid_ff    <= rsp_dates_valid_in;
      rsp_day_difference_ff <= rsp_day_difference_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_dates_valid    = rsp_dates_valid_ff;
   assign rsp_day_difference = rsp_day_difference_ff;

   `DBD_ASSERT_LAT3(a_accept_gives_result, accept, rsp_strobe, "accepted item produced no result")
   `DBD_ASSERT_SAME(a_result_has_item, rsp_strobe, $past(accept, 3), "result without an item")
   `DBD_ASSERT_SAME(a_invalid_zero, rsp_strobe && !rsp_dates_valid, rsp_day_difference == '0, "invalid result not zero")
   `DBD_ASSERT_SAME(a_same_date_zero, s2_valid_ff && first_back.valid && (first_back.dnum == second_back.dnum), ##1 (rsp_day_difference == '0), "equal dates gave nonzero difference")

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the days-between-dates block: directed rows, then random items.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dbd_pkg::*;

   localparam int unsigned MaxYear   = 9999;
   localparam int unsigned RandItems = 1250;
   localparam int unsigned Latency   = 3;
   localparam int unsigned MaxGap    = 20;

   typedef logic [DayWidth-1:0]         day_type;
   typedef logic [MonthWidth-1:0]       month_type;
   typedef logic [YearWidth-1:0]        year_type;
   typedef logic signed [DnumWidth-1:0] diff_type;

   typedef struct packed {
      logic     valid;
      diff_type diff;
   } span_type;

   typedef struct packed {
      day_type   d1;
      month_type m1;
      year_type  y1;
      day_type   d2;
      month_type m2;
      year_type  y2;
      logic      typed;  // span below holds the expected result
      span_type  span;
   } row_type;

   localparam int MonthDays[12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int DaysBefore[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   // Directed rows: d1, m1, y1, d2, m2, y2, typed, expected span
   localparam int NumRows = 23;
   localparam row_type DirRows[NumRows] = '{
      '{ 1,  1,     1,  1,  1,     1, 1, '{1,        0}},
      '{ 1,  1,     1, 31, 12,  9999, 1, '{1,  3652058}},
      '{31, 12,  9999,  1,  1,     1, 1, '{1, -3652058}},
      '{ 0,  1,  2000,  1,  1,  2000, 1, '{0,        0}},
      '{31, 15,  2000,  1,  1,  2000, 1, '{0,        0}},
      '{ 1,  0,  2000,  1,  1,  2000, 1, '{0,        0}},
      '{ 1,  1,  2000,  1, 13,  2000, 1, '{0,        0}},
      '{ 1,  1,     0,  1,  1,  2000, 1, '{0,        0}},
      '{ 1,  1,  2000,  1,  1, 10000, 1, '{0,        0}},
      '{ 1,  1, 16383,  1,  1,  2000, 1, '{0,        0}},
      '{29,  2,  2000,  1,  3,  2000, 1, '{1,        1}},
      '{29,  2,  1900,  1,  3,  1900, 1, '{0,        0}},
      '{29,  2,  2024, 28,  2,  2025, 0, '{0,        0}},
      '{ 1,  1,  2023, 29,  2,  2023, 1, '{0,        0}},
      '{31,  4,  2020,  1,  5,  2020, 1, '{0,        0}},
      '{31, 12,  1999,  1,  1,  2000, 1, '{1,        1}},
      '{28,  2,  2100,  1,  3,  2100, 1, '{1,        1}},
      '{31, 15, 16383, 31, 15, 16383, 1, '{0,        0}},
      '{ 0,  0,     0,  0,  0,     0, 1, '{0,        0}},
      '{31,  1,  9999,  1,  2,  9999, 0, '{0,        0}},
      '{15,  6,  1970,  4,  7,  2023, 0, '{0,        0}},
      '{ 1,  1,     1,  1,  1,     2, 1, '{1,      365}},
      '{ 1,  1,     4,  1,  1,     5, 1, '{1,      366}}
   };

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   day_type   req_first_day    = '0;
   month_type req_first_month  = '0;
   year_type  req_first_year   = '0;
   day_type   req_second_day   = '0;
   month_type req_second_month = '0;
   year_type  req_second_year  = '0;
   logic      rsp_strobe;
   logic      rsp_dates_valid;
   diff_type  rsp_day_difference;

   // Sideband that travels with each item: typed expectation, if any
   logic      item_typed = 1'b0;
   span_type  item_span  = '0;

   span_type    pending_spans[$];
   int unsigned fault_count = 0;

   days_between_dates #(.MAX_YEAR(MaxYear)) dut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_first_day,
      .req_first_month,
      .req_first_year,
      .req_second_day,
      .req_second_month,
      .req_second_year,
      .rsp_strobe,
      .rsp_dates_valid,
      .rsp_day_difference
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(int m, int y);
      return (m == MonthFeb && leap_year(y)) ? 29 : MonthDays[m-1];
   endfunction

   function automatic bit date_valid(day_type d, month_type m, year_type y);
      if (m < MonthJan || m > MonthDec || y < 1 || y > MaxYear || d < 1) begin
         return 1'b0;
      end
      return d <= days_in_month(m, y);
   endfunction

   // Days since the start of year 1, first of January being day 1
   function automatic int day_serial(day_type d, month_type m, year_type y);
      int py;
      py = y - 1;
      return 365 * py + py / 4 - py / 100 + py / 400 + DaysBefore[m-1]
         + ((m > MonthFeb && leap_year(y)) ? 1 : 0) + d;
   endfunction

   function automatic span_type span_between(day_type d1, month_type m1, year_type y1,
                                             day_type d2, month_type m2, year_type y2);
      span_type s;
      s = '0;
      if (date_valid(d1, m1, y1) && date_valid(d2, m2, y2)) begin
         s.valid = 1'b1;
         s.diff  = diff_type'(day_serial(d2, m2, y2) - day_serial(d1, m1, y1));
      end
      return s;
   endfunction

   // Pick a valid date; a nonzero fix_year pins the year
   task automatic pick_date(input int fix_year, output day_type d, output month_type m,
                            output year_type y);
      int len;
      if (fix_year != 0) begin
         y = year_type'(fix_year);
      end else begin
         case ($urandom_range(7, 0))
            0: y = year_type'(1);
            1: y = year_type'(MaxYear);
            2: y = year_type'(400 * $urandom_range(24, 1));
            3: y = year_type'(100 * $urandom_range(99, 1));
            default: y = year_type'($urandom_range(MaxYear, 1));
         endcase
      end
      m   = month_type'($urandom_range(MonthDec, MonthJan));
      len = days_in_month(m, y);
      d   = day_type'(($urandom_range(3, 0) == 0) ? len : $urandom_range(len, 1));
   endtask

   // Hold start low for a random gap, then present one item until it is taken
   task automatic drive_item(input day_type d1, input month_type m1, input year_type y1,
                             input day_type d2, input month_type m2, input year_type y2,
                             input logic typed, input span_type span,
                             input int unsigned idle_pct);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99, 0) < idle_pct && gap < MaxGap) begin
         gap++;
      end
      if (gap != 0) begin
         start <= 1'b0;
         {req_first_day, req_first_month, req_first_year,
          req_second_day, req_second_month, req_second_year} <= 46'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_first_day    <= d1;
      req_first_month  <= m1;
      req_first_year   <= y1;
      req_second_day   <= d2;
      req_second_month <= m2;
      req_second_year  <= y2;
      item_typed       <= typed;
      item_span        <= span;
      do @(posedge clock); while (busy);
   endtask

   // Record each accepted item and check each strobed result against the oldest one
   always @(posedge clock) begin
      span_type want;
      if (!reset) begin
         if (start && !busy) begin
            pending_spans.push_back(item_typed ? item_span :
               span_between(req_first_day, req_first_month, req_first_year,
                            req_second_day, req_second_month, req_second_year));
         end
         if (rsp_strobe) begin
            if (pending_spans.size() == 0) begin
               $display("%0t: result with no item pending: valid=%0b diff=%0d",
                        $time, rsp_dates_valid, rsp_day_difference);
               fault_count++;
            end else begin
               want = pending_spans.pop_front();
               if (rsp_dates_valid !== want.valid) begin
                  $display("%0t: dates_valid mismatch: expected %0b, actual %0b",
                           $time, want.valid, rsp_dates_valid);
                  fault_count++;
               end
               if (rsp_day_difference !== want.diff) begin
                  $display("%0t: day_difference mismatch: expected %0d, actual %0d",
                           $time, want.diff, rsp_day_difference);
                  fault_count++;
               end
            end
         end
      end
   end

   initial begin
      int unsigned idle_pct[4];
      day_type     d1, d2;
      month_type   m1, m2;
      year_type    y1, y2;
      int unsigned guard;

      idle_pct = '{0, 51, 7, 0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      foreach (DirRows[i]) begin
         drive_item(DirRows[i].d1, DirRows[i].m1, DirRows[i].y1,
                    DirRows[i].d2, DirRows[i].m2, DirRows[i].y2,
                    DirRows[i].typed, DirRows[i].span, idle_pct[i % 2]);
      end

      // Random items, mostly valid date pairs, in phases of sender idling
      for (int n = 0; n < RandItems; n++) begin
         pick_date(0, d1, m1, y1);
         pick_date(($urandom_range(2, 0) == 0) ? int'(y1) : 0, d2, m2, y2);
         case ($urandom_range(19, 0))
            0, 1: begin
               {d1, m1, y1, d2, m2, y2} = 46'({$urandom, $urandom});
            end
            2: begin
               if ($urandom_range(1, 0)) d1 = day_type'(days_in_month(m1, y1) + 1);
               else                      d2 = day_type'(days_in_month(m2, y2) + 1);
            end
            3: begin
               m2 = $urandom_range(1, 0) ? month_type'(0) :
                                           month_type'($urandom_range(15, 13));
            end
            4: begin
               y1 = $urandom_range(1, 0) ? year_type'(0) :
                                           year_type'($urandom_range(16383, MaxYear + 1));
            end
            default: ;
         endcase
         drive_item(d1, m1, y1, d2, m2, y2, 1'b0, '0, idle_pct[n * 4 / RandItems]);
      end
      start <= 1'b0;

      // Drain outstanding results
      guard = 0;
      while (pending_spans.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (Latency + 4) @(posedge clock);
      if (pending_spans.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_spans.size());
         fault_count++;
      end

      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop on a hung run
   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
